FILE: rtl/core/tle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

    // Line store depth default
    localparam int LINE_MAX_DEF = 31;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int KIND_W      = 2;
    localparam int LIMIT_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ECHO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd31;

    // Console characters
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    // Commands from controller to datapath
    typedef struct packed {
        logic              edit_insert;
        logic              edit_erase;
        logic              move_left;
        logic              move_right;
        logic              ptr_zero;
        logic              ptr_inc;
        logic              cnt_dec;
        logic              clear_line;
        logic              emit;
        logic              src_store;
        logic              last;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] lit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic echo_en;
        logic out_free;
        logic can_insert;
        logic cursor_nz;
        logic can_right;
        logic len_zero;
        logic ptr_last;
        logic cnt_zero;
        logic cnt_one;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/tle_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tle_datapath #(
    parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tle_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [tle_pkg::BYTE_W-1:0]       i_in_byte,
    input  wire tle_pkg::t_dp_cmd                 i_cmd,
    output tle_pkg::t_dp_status                   o_status,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [tle_pkg::OUT_TDATA_W-1:0]       o_out_data,  // out_byte, line_length
    output logic [tle_pkg::OUT_TUSER_W-1:0]       o_out_kind,  // out_kind
    output logic                                  o_out_last
);
    import tle_pkg::*;

    localparam int W  = $clog2(LINE_MAX + 1);
    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [LIMIT_W-1:0] CAP_MAX = LIMIT_W'(LINE_MAX);

    logic [BYTE_W-1:0]  r_store [0:LINE_MAX-1];
    logic [BYTE_W-1:0]  n_store [0:LINE_MAX-1];
    logic [BYTE_W-1:0]  w_from_left  [0:LINE_MAX-1];
    logic [BYTE_W-1:0]  w_from_right [0:LINE_MAX-1];
    logic [W-1:0]       r_cursor;
    logic [W-1:0]       r_length;
    logic [W-1:0]       r_ptr;
    logic [W-1:0]       r_cnt;
    logic               r_echo_en;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] w_cap;
    logic [BYTE_W-1:0]  w_rd;
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_last;

    // Configuration registers: always ready, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en <= 1'b1;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_ECHO:  r_echo_en <= i_cfg_data[0];
                CFG_IDX_LIMIT: r_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Neighbor taps for the shift moves
    genvar g;
    for (g = 0; g < LINE_MAX; g++) begin : g_tap
        if (g == 0) begin : g_lo
            assign w_from_left[g] = CH_NUL;
        end else begin : g_lo
            assign w_from_left[g] = r_store[g-1];
        end
        if (g == LINE_MAX - 1) begin : g_hi
            assign w_from_right[g] = CH_NUL;
        end else begin : g_hi
            assign w_from_right[g] = r_store[g+1];
        end
    end

    // Insert shifts the tail right, erase shifts it left over the gap
    always_comb begin
        for (int i = 0; i < LINE_MAX; i++) begin
            n_store[i] = r_store[i];
            if (i_cmd.edit_insert) begin
                if (W'(i) == r_cursor) begin
                    n_store[i] = i_in_byte;
                end else if (W'(i) > r_cursor && W'(i) <= r_length) begin
                    n_store[i] = w_from_left[i];
                end
            end else if (i_cmd.edit_erase) begin
                if (W'(i + 1) >= r_cursor && W'(i + 1) < r_length) begin
                    n_store[i] = w_from_right[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    // Cursor, length, read pointer and backspace count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_length <= '0;
            r_ptr    <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.edit_insert) begin
                r_cursor <= r_cursor + W'(1);
                r_length <= r_length + W'(1);
                r_ptr    <= r_cursor;
                r_cnt    <= r_length - r_cursor;
            end else if (i_cmd.edit_erase) begin
                r_cursor <= r_cursor - W'(1);
                r_length <= r_length - W'(1);
                r_ptr    <= r_cursor - W'(1);
                r_cnt    <= r_length - r_cursor;
            end else if (i_cmd.move_left) begin
                r_cursor <= r_cursor - W'(1);
            end else if (i_cmd.move_right) begin
                r_cursor <= r_cursor + W'(1);
            end else if (i_cmd.clear_line) begin
                r_cursor <= '0;
                r_length <= '0;
            end
            if (i_cmd.ptr_zero) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + W'(1);
            end
            if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - W'(1);
            end
        end
    end

    // Capacity is the smaller of the limit register and the store depth
    assign w_cap = (r_limit < CAP_MAX) ? r_limit : CAP_MAX;
    assign w_rd  = r_store[r_ptr[AW-1:0]];

    always_comb begin
        o_status.echo_en    = r_echo_en;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.can_insert = LIMIT_W'(r_length) < w_cap;
        o_status.cursor_nz  = r_cursor != '0;
        o_status.can_right  = r_cursor < r_length;
        o_status.len_zero   = r_length == '0;
        o_status.ptr_last   = (r_ptr + W'(1)) == r_length;
        o_status.cnt_zero   = r_cnt == '0;
        o_status.cnt_one    = r_cnt == W'(1);
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            r_out_byte <= i_cmd.src_store ? w_rd : i_cmd.lit;
            r_out_len  <= (i_cmd.kind == KIND_END) ? LEN_W'(r_length) : '0;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W - BYTE_W - LEN_W){1'b0}}, r_out_len, r_out_byte};
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/tle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tle_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [tle_pkg::BYTE_W-1:0] i_in_byte,
    input  wire tle_pkg::t_dp_status        i_status,
    output tle_pkg::t_dp_cmd                o_cmd
);
    import tle_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_LF   = 4'd2;
    localparam logic [3:0] S_LINE = 4'd3;
    localparam logic [3:0] S_END  = 4'd4;
    localparam logic [3:0] S_ESC  = 4'd5;
    localparam logic [3:0] S_BRK  = 4'd6;
    localparam logic [3:0] S_DIR  = 4'd7;
    localparam logic [3:0] S_STR  = 4'd8;
    localparam logic [3:0] S_BSA  = 4'd9;
    localparam logic [3:0] S_SPC  = 4'd10;
    localparam logic [3:0] S_BSB  = 4'd11;
    localparam logic [3:0] S_BSN  = 4'd12;

    // Escape parser modes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_CR      = 2'd1;
    localparam logic [1:0] MODE_ESC     = 2'd2;
    localparam logic [1:0] MODE_BRACKET = 2'd3;

    logic [3:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic       r_right, n_right;
    logic       r_erase, n_erase;
    logic       w_accept;
    logic       w_normal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_NORMAL;
            r_right <= 1'b0;
            r_erase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_right <= n_right;
            r_erase <= n_erase;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_right  = r_right;
        n_erase  = r_erase;
        w_normal = 1'b0;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Decode the byte against the parser mode
                    case (r_mode)
                        MODE_CR: begin
                            n_mode   = MODE_NORMAL;
                            w_normal = (i_in_byte != CH_LF);
                        end
                        MODE_ESC: begin
                            n_mode = (i_in_byte == CH_LBRK) ? MODE_BRACKET : MODE_NORMAL;
                        end
                        MODE_BRACKET: begin
                            n_mode = MODE_NORMAL;
                            if (i_in_byte == CH_D && i_status.cursor_nz) begin
                                o_cmd.move_left = 1'b1;
                                n_right = 1'b0;
                                if (i_status.echo_en) n_state = S_ESC;
                            end else if (i_in_byte == CH_C && i_status.can_right) begin
                                o_cmd.move_right = 1'b1;
                                n_right = 1'b1;
                                if (i_status.echo_en) n_state = S_ESC;
                            end
                        end
                        default: w_normal = 1'b1;
                    endcase
                    if (w_normal) begin
                        if (i_in_byte inside {CH_CR, CH_LF}) begin
                            o_cmd.ptr_zero = 1'b1;
                            n_mode = (i_in_byte == CH_CR) ? MODE_CR : MODE_NORMAL;
                            if (i_status.echo_en) begin
                                n_state = S_CR;
                            end else begin
                                n_state = i_status.len_zero ? S_END : S_LINE;
                            end
                        end else if (i_in_byte inside {CH_BS, CH_DEL}) begin
                            if (i_status.cursor_nz) begin
                                o_cmd.edit_erase = 1'b1;
                                n_erase = 1'b1;
                                if (i_status.echo_en) n_state = S_BSA;
                            end
                        end else if (i_in_byte == CH_ESC) begin
                            n_mode = MODE_ESC;
                        end else if (i_status.can_insert) begin
                            o_cmd.edit_insert = 1'b1;
                            n_erase = 1'b0;
                            if (i_status.echo_en) n_state = S_STR;
                        end
                    end
                end
            end
            // Line end echo: CR LF
            S_CR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_CR;
                    n_state    = S_LF;
                end
            end
            S_LF: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_LF;
                    n_state    = i_status.len_zero ? S_END : S_LINE;
                end
            end
            // Completed line bytes, then the end marker
            S_LINE: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = KIND_LINE;
                    o_cmd.src_store = 1'b1;
                    o_cmd.ptr_inc   = 1'b1;
                    if (i_status.ptr_last) n_state = S_END;
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = KIND_END;
                    o_cmd.lit        = CH_NUL;
                    o_cmd.last       = 1'b1;
                    o_cmd.clear_line = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            // Cursor move echo
            S_ESC: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_ESC;
                    n_state    = S_BRK;
                end
            end
            S_BRK: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_LBRK;
                    n_state    = S_DIR;
                end
            end
            S_DIR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = r_right ? CH_C : CH_D;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            // Redraw the tail from the read pointer
            S_STR: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = KIND_ECHO;
                    o_cmd.src_store = 1'b1;
                    o_cmd.ptr_inc   = 1'b1;
                    if (i_status.ptr_last) begin
                        if (r_erase) begin
                            n_state = S_SPC;
                        end else if (i_status.cnt_zero) begin
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_BSN;
                        end
                    end
                end
            end
            // Erase echo: backspace, tail, space, backspace
            S_BSA: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_BS;
                    n_state    = i_status.cnt_zero ? S_SPC : S_STR;
                end
            end
            S_SPC: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_SPACE;
                    n_state    = S_BSB;
                end
            end
            S_BSB: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.lit  = CH_BS;
                    o_cmd.last = i_status.cnt_zero;
                    n_state    = i_status.cnt_zero ? S_IDLE : S_BSN;
                end
            end
            // Walk the cursor back over the tail
            S_BSN: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = KIND_ECHO;
                    o_cmd.lit     = CH_BS;
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.last    = i_status.cnt_one;
                    if (i_status.cnt_one) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/terminal_line_editor_core.sv
// A byte's results, up to LINE_MAX + 3 for a line end, come one result per cycle while
// the output register is free, out of a single sequencer walking the line store; each
// result is registered in the output register by a state after the byte's transaction.
// The next byte is taken once the last result is loaded into the output register.
// Reset (synchronous, active low) clears cursor, length, parser mode, output valid and
// restores echo on and limit 31; the line store keeps its contents.
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_editor_core #(
    parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [tle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [tle_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // [7:0] out_byte,
                                                                  // [12:8] line_length
    output logic [tle_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,   // [1:0] out_kind
    output logic                                  m_axis_tlast,   // last
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tle_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tle_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tle_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_byte  (s_axis_tdata[BYTE_W-1:0]),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tle_datapath #(
        .LINE_MAX (LINE_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // An end marker always closes the results of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_END) |-> m_axis_tlast)
        else $error("end marker without tlast");

    // Only the end marker carries a length
    a_len_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_END) |-> (m_axis_tdata[12:8] == '0))
        else $error("length on a non-end result");

    // A new byte is taken only after the previous byte's last result is out
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && s_axis_tready |-> m_axis_tlast)
        else $error("input ready while results of a byte remain");

endmodule

`default_nettype wire
